>>> src/gnt_pkg.sv
// gnt_pkg: shared types and constants of the greedy neighbor table.
// No dependencies.
package gnt_pkg;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_DELETE = 3'd1,
		OP_QUERY  = 3'd2,
		OP_HOP    = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_EVAL,
		ST_SETTLE,
		ST_FINAL,
		ST_DONE
	} state_t;

	localparam logic [19:0] LIFETIME_RESET = 20'd2000;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request
		logic rd_en;    // issue a slot read
		logic eval;     // process slot read last cycle
		logic finish;   // apply write and form result
		logic emit;     // result strobe
	} gnt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;  // the read address is the last slot
		logic no_scan;    // op needs no table scan
	} gnt_sts_t;

endpackage

>>> src/greedy_neighbour_table_core.sv
// greedy_neighbour_table_core: top level of the greedy neighbor table.
// Depends on gnt_pkg, gnt_ctrl, gnt_dp (and gnt_ram below it).
//
// Channel   | Handshake         | Payload
// request   | start / busy      | op, now_ms, addr, pos_*, self_*
// result    | done (1 cycle)    | next_hop, hit, entry_count, table_full
// config    | lifetime_we       | lifetime_data (entry_lifetime)
//
// A scanning request reads one slot per cycle from the slot RAM, and each
// slot goes through a difference, square and compare pipeline. Clear,
// unused codes and zero-address add/delete skip the scan.
// Reset clears the valid bits and count at once; no clearing pass.
// Results cannot be stalled; busy drops in the done cycle, so the next
// request is accepted at the earliest at the edge that ends the strobe.
module greedy_neighbour_table_core
	import gnt_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int COORD_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        lifetime_we,
	input  logic [19:0] lifetime_data,
	input  logic [2:0]  op,
	input  logic [31:0] now_ms,
	input  logic [31:0] addr,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [COORD_WIDTH-1:0] self_x,
	input  logic signed [COORD_WIDTH-1:0] self_y,
	input  logic signed [COORD_WIDTH-1:0] self_z,
	output logic        done,
	output logic [31:0] next_hop,
	output logic        hit,
	output logic [5:0]  entry_count,
	output logic        table_full
);
	gnt_cmd_t cmd;
	gnt_sts_t sts;

	gnt_ctrl u_ctrl (.clk, .arst_n, .start, .sts, .cmd, .busy);

	gnt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.cfg_we(lifetime_we), .cfg_data(lifetime_data),
		.op, .now_ms, .addr, .pos_x, .pos_y, .pos_z,
		.self_x, .self_y, .self_z,
		.next_hop, .hit, .entry_count, .table_full, .done
	);
endmodule

>>> src/gnt_ram.sv
// gnt_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
module gnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

>>> src/gnt_ctrl.sv
// gnt_ctrl: sequencer of one request: slot scan, evaluation, result.
// Depends on gnt_pkg.
module gnt_ctrl
	import gnt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  gnt_sts_t sts,
	output gnt_cmd_t cmd,
	output logic     busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.no_scan) begin
					state_d = ST_FINAL;
				end else begin
					cmd.rd_en = 1'b1;
					if (sts.scan_last)
						state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				cmd.eval = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				// products of the last slot settle here
				state_d = ST_SETTLE;
			end
			ST_SETTLE: begin
				// last slot reaches the best-distance compare
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> src/gnt_dp.sv
// gnt_dp: slot memories, valid bits, distance arithmetic and result registers.
// Depends on gnt_pkg and gnt_ram.
module gnt_dp
	import gnt_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int COORD_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gnt_cmd_t               cmd,
	output gnt_sts_t               sts,
	input  logic                   cfg_we,
	input  logic [19:0]            cfg_data,
	input  logic [2:0]             op,
	input  logic [31:0]            now_ms,
	input  logic [31:0]            addr,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [COORD_WIDTH-1:0] self_x,
	input  logic signed [COORD_WIDTH-1:0] self_y,
	input  logic signed [COORD_WIDTH-1:0] self_z,
	output logic [31:0]            next_hop,
	output logic                   hit,
	output logic [5:0]             entry_count,
	output logic                   table_full,
	output logic                   done
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int DW = COORD_WIDTH + 1;
	localparam int SW = 2 * DW + 2;
	localparam int RW = 32 + 3 * COORD_WIDTH + 32;

	logic [19:0] life_q;
	logic [2:0]  op_q;
	logic [31:0] now_q, addr_q;
	logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q, sx_q, sy_q, sz_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] ra_q, idx_s1;
	logic ev_s1, ev_s2;

	// scan results
	logic found_q;
	logic [IW-1:0] found_idx_q;
	logic have_q;
	logic [SW-1:0] best_q;
	logic [31:0] best_addr_q;
	logic [TABLE_DEPTH-1:0] expire_q;

	// memory
	logic we;
	logic [IW-1:0] wa;
	logic [RW-1:0] wd, rd;

	gnt_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk, .we, .waddr(wa), .wdata(wd),
		.re(cmd.rd_en), .raddr(ra_q), .rdata(rd)
	);

	logic [31:0] r_addr, r_stamp;
	logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;
	assign {r_addr, r_x, r_y, r_z, r_stamp} = rd;

	logic is_add, is_del, is_q, is_hop;
	assign is_add = op_q == OP_ADD;
	assign is_del = op_q == OP_DELETE;
	assign is_q   = op_q == OP_QUERY;
	assign is_hop = op_q == OP_HOP;

	// queries always scan: expiry applies whatever the address
	assign sts.no_scan   = !(is_add || is_del || is_q || is_hop) ||
	                       (addr_q == '0 && (is_add || is_del));
	assign sts.scan_last = ra_q == IW'(TABLE_DEPTH - 1);

	// stage 1 registers: slot fields and differences
	logic [31:0] a_s1;
	logic age_ok_s1, live_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	// stage 2: squares
	logic [SW-1:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic [31:0] a_s2;
	logic live_s2;

	logic [31:0] age;
	assign age = now_q - r_stamp;

	logic [SW-1:0] d2;
	assign d2 = sq_x_s2 + sq_y_s2 + sq_z_s2;

	// self distance
	logic signed [DW-1:0] sdx, sdy, sdz;
	logic [SW-1:0] self_q;
	assign sdx = DW'(sx_q) - DW'(px_q);
	assign sdy = DW'(sy_q) - DW'(py_q);
	assign sdz = DW'(sz_q) - DW'(pz_q);

	logic [IW-1:0] first_free;
	logic any_free;
	always_comb begin
		first_free = '0;
		any_free = 1'b0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--)
			if (!valid_q[i]) begin
				first_free = IW'(i);
				any_free = 1'b1;
			end
	end

	logic new_add;
	assign new_add = is_add && addr_q != '0 && !found_q && any_free;

	always_comb begin
		we = cmd.finish && is_add && addr_q != '0 && (found_q || any_free);
		wa = found_q ? found_idx_q : first_free;
		wd = {addr_q, px_q, py_q, pz_q, now_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q  <= LIFETIME_RESET;
			valid_q <= '0;
			count_q <= '0;
			done    <= 1'b0;
			ev_s1   <= 1'b0;
			ev_s2   <= 1'b0;
		end else begin
			if (cfg_we)
				life_q <= cfg_data;
			done  <= cmd.emit;
			ev_s1 <= cmd.rd_en;
			ev_s2 <= ev_s1;
			if (cmd.finish) begin
				if (op_q == OP_CLEAR) begin
					valid_q <= '0;
					count_q <= '0;
				end else if (is_q || is_hop) begin
					valid_q <= valid_q & ~expire_q;
					count_q <= count_q - CW'($countones(expire_q));
				end else if (is_del && found_q) begin
					valid_q[found_idx_q] <= 1'b0;
					count_q <= count_q - 1'b1;
				end else if (new_add) begin
					valid_q[first_free] <= 1'b1;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op; now_q <= now_ms; addr_q <= addr;
			px_q <= pos_x; py_q <= pos_y; pz_q <= pos_z;
			sx_q <= self_x; sy_q <= self_y; sz_q <= self_z;
			ra_q <= '0;
			found_q <= 1'b0; found_idx_q <= '0;
			have_q <= 1'b0; best_q <= '0; best_addr_q <= '0;
			expire_q <= '0;
		end
		if (cmd.rd_en) begin
			ra_q <= ra_q + 1'b1;
			idx_s1 <= ra_q;
		end
		// stage 1
		live_s1 <= valid_q[idx_s1];
		a_s1 <= r_addr;
		age_ok_s1 <= age < {12'd0, life_q};
		dx_s1 <= DW'(r_x) - DW'(px_q);
		dy_s1 <= DW'(r_y) - DW'(py_q);
		dz_s1 <= DW'(r_z) - DW'(pz_q);
		if (ev_s1) begin
			if (valid_q[idx_s1] && (is_q || is_hop) && !(age < {12'd0, life_q}))
				expire_q[idx_s1] <= 1'b1;
			if (valid_q[idx_s1] && r_addr == addr_q &&
			    ((is_add || is_del) || age < {12'd0, life_q})) begin
				found_q <= 1'b1;
				found_idx_q <= idx_s1;
			end
		end
		// stage 2: one multiplier per axis
		sq_x_s2 <= SW'(dx_s1 * dx_s1);
		sq_y_s2 <= SW'(dy_s1 * dy_s1);
		sq_z_s2 <= SW'(dz_s1 * dz_s1);
		a_s2 <= a_s1;
		live_s2 <= live_s1 && age_ok_s1 && ev_s2;
		// stage 3: best tracking
		if (live_s2 && is_hop &&
		    (!have_q || d2 < best_q || (d2 == best_q && a_s2 < best_addr_q))) begin
			have_q <= 1'b1;
			best_q <= d2;
			best_addr_q <= a_s2;
		end
		self_q <= SW'(sdx * sdx) + SW'(sdy * sdy) + SW'(sdz * sdz);
		if (cmd.finish) begin
			next_hop   <= (is_hop && have_q && self_q > best_q) ? best_addr_q : '0;
			hit        <= (is_q || is_add) && addr_q != '0 && found_q;
			table_full <= is_add && addr_q != '0 && !found_q && !any_free;
		end
	end

	logic [CW-1:0] cnt_now;
	assign cnt_now = count_q;
	assign entry_count = 6'(cnt_now);
endmodule

>>> test/testbench.sv
// testbench: self-checking regression of greedy_neighbour_table_core.
// Depends on gnt_pkg and the core; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module testbench
	import gnt_pkg::*;
();

	localparam int DEPTH = 32;
	localparam int CW = 24;
	localparam int LIMIT = 1000000;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now_ms;
		logic [31:0] addr;
		logic signed [CW-1:0] px, py, pz, sx, sy, sz;
	} request_t;

	typedef struct packed {
		logic [31:0] next_hop;
		logic        hit;
		logic [5:0]  entry_count;
		logic        table_full;
	} answer_t;

	class neighbor_scoreboard;
		bit          valid [DEPTH];
		logic [31:0] address [DEPTH];
		logic signed [CW-1:0] sx [DEPTH], sy [DEPTH], sz [DEPTH];
		logic [31:0] stamp [DEPTH];
		int          count;
		logic [19:0] lifetime;
		answer_t     pending [$];
		int          errors;

		function void clear_state();
			foreach (valid[i]) valid[i] = 0;
			count = 0;
			lifetime = LIFETIME_RESET;
			errors = 0;
		endfunction

		function int find(logic [31:0] a);
			for (int i = 0; i < DEPTH; i++)
				if (valid[i] && address[i] == a) return i;
			return -1;
		endfunction

		function void age_out(logic [31:0] now);
			logic [31:0] age;
			for (int i = 0; i < DEPTH; i++) begin
				age = now - stamp[i];
				if (valid[i] && age >= {12'd0, lifetime}) begin
					valid[i] = 0;
					count--;
				end
			end
		endfunction

		function longint unsigned dist2(logic signed [CW-1:0] ax, ay, az, bx, by, bz);
			longint dx, dy, dz;
			dx = longint'(ax) - longint'(bx);
			dy = longint'(ay) - longint'(by);
			dz = longint'(az) - longint'(bz);
			return dx * dx + dy * dy + dz * dz;
		endfunction

		function void note_request(request_t r);
			answer_t ans;
			int k;
			bit have;
			longint unsigned best, d;
			logic [31:0] best_addr;
			ans = '0;
			case (r.op)
			OP_ADD: begin
				if (r.addr != 0) begin
					k = find(r.addr);
					if (k >= 0) ans.hit = 1;
					else begin
						for (k = 0; k < DEPTH; k++) if (!valid[k]) break;
						if (k < DEPTH) begin
							valid[k] = 1;
							address[k] = r.addr;
							count++;
						end else begin
							ans.table_full = 1;
							k = -1;
						end
					end
					if (k >= 0) begin
						sx[k] = r.px; sy[k] = r.py; sz[k] = r.pz;
						stamp[k] = r.now_ms;
					end
				end
			end
			OP_DELETE: begin
				k = (r.addr != 0) ? find(r.addr) : -1;
				if (k >= 0) begin
					valid[k] = 0;
					count--;
				end
			end
			OP_QUERY: begin
				age_out(r.now_ms);
				ans.hit = (r.addr != 0 && find(r.addr) >= 0);
			end
			OP_HOP: begin
				age_out(r.now_ms);
				have = 0; best = 0; best_addr = 0;
				for (int i = 0; i < DEPTH; i++) if (valid[i]) begin
					d = dist2(sx[i], sy[i], sz[i], r.px, r.py, r.pz);
					if (!have || d < best || (d == best && address[i] < best_addr)) begin
						have = 1; best = d; best_addr = address[i];
					end
				end
				if (have && dist2(r.sx, r.sy, r.sz, r.px, r.py, r.pz) > best)
					ans.next_hop = best_addr;
			end
			OP_CLEAR: begin
				foreach (valid[i]) valid[i] = 0;
				count = 0;
			end
			default: ;
			endcase
			ans.entry_count = count[5:0];
			pending.push_back(ans);
		endfunction

		function void check_answer(answer_t got);
			answer_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result strobe");
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.next_hop !== exp.next_hop) begin
				$error("next_hop expected %h actual %h", exp.next_hop, got.next_hop);
				errors++;
			end
			if (got.hit !== exp.hit) begin
				$error("hit expected %b actual %b", exp.hit, got.hit);
				errors++;
			end
			if (got.entry_count !== exp.entry_count) begin
				$error("entry_count expected %0d actual %0d", exp.entry_count,
					got.entry_count);
				errors++;
			end
			if (got.table_full !== exp.table_full) begin
				$error("table_full expected %b actual %b", exp.table_full, got.table_full);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic lifetime_we = 0;
	logic [19:0] lifetime_data = '0;
	request_t req = '0;
	logic done;
	logic [31:0] next_hop;
	logic hit;
	logic [5:0] entry_count;
	logic table_full;

	neighbor_scoreboard board;
	int cycle_count = 0;
	bit quiet_stretch = 0;
	logic [31:0] clock_ms = 0;
	logic [31:0] known_addr [8];

	always #10 clk = ~clk;

	greedy_neighbour_table_core #(.TABLE_DEPTH(DEPTH), .COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lifetime_we(lifetime_we), .lifetime_data(lifetime_data),
		.op(req.op), .now_ms(req.now_ms), .addr(req.addr),
		.pos_x(req.px), .pos_y(req.py), .pos_z(req.pz),
		.self_x(req.sx), .self_y(req.sy), .self_z(req.sz),
		.done(done), .next_hop(next_hop), .hit(hit),
		.entry_count(entry_count), .table_full(table_full)
	);

	// results are checked at the edge that ends their strobe cycle
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && done)
			board.check_answer({next_hop, hit, entry_count, table_full});
		if (cycle_count > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// hands one request over; start stays up until accepted and drops
	// only on an idle cycle or in drain
	task automatic send_request(request_t r);
		if (!quiet_stretch)
			while ($urandom_range(99) < 38) begin
				start <= 0;
				@(posedge clk);
			end
		req <= r;
		start <= 1;
		do @(posedge clk); while (busy);
		board.note_request(r);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic set_lifetime(logic [19:0] v);
		drain();
		lifetime_we <= 1;
		lifetime_data <= v;
		@(posedge clk);
		board.lifetime = v;
		lifetime_we <= 0;
	endtask

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(5))
		0: return {1'b1, {(CW-1){1'b0}}};
		1: return {1'b0, {(CW-1){1'b1}}};
		2: return CW'($urandom_range(7)) - CW'(3);
		default: return CW'($urandom);
		endcase
	endfunction

	function automatic request_t make_request(logic [2:0] o, logic [31:0] a);
		request_t r;
		r.op = o; r.addr = a; r.now_ms = clock_ms;
		r.px = rand_coord(); r.py = rand_coord(); r.pz = rand_coord();
		r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
		return r;
	endfunction

	// mostly table traffic on a small address pool so hits and refreshes occur
	task automatic random_phase(int n, int pool);
		request_t r;
		logic [31:0] a;
		int pick;
		for (int i = 0; i < n; i++) begin
			clock_ms = clock_ms + $urandom_range(board.lifetime / 4 + 2);
			if ($urandom_range(30) == 0) clock_ms = $urandom;
			a = known_addr[$urandom_range(pool - 1)];
			if ($urandom_range(15) == 0) a = $urandom;
			if ($urandom_range(40) == 0) a = 0;
			pick = $urandom_range(99);
			if (pick < 45) r = make_request(OP_ADD, a);
			else if (pick < 55) r = make_request(OP_DELETE, a);
			else if (pick < 70) r = make_request(OP_QUERY, a);
			else if (pick < 96) r = make_request(OP_HOP, a);
			else if (pick < 98) r = make_request(OP_CLEAR, a);
			else r = make_request(3'($urandom_range(5, 7)), a);
			send_request(r);
		end
	endtask

	initial begin
		request_t r;
		board = new();
		board.clear_state();
		foreach (known_addr[i]) known_addr[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: address zero, refresh, empty hop, extremes, unused codes
		send_request(make_request(OP_HOP, 1));
		send_request(make_request(OP_ADD, 0));
		send_request(make_request(OP_ADD, 32'hFFFF_FFFF));
		send_request(make_request(OP_ADD, 32'hFFFF_FFFF));
		send_request(make_request(OP_ADD, 1));
		send_request(make_request(OP_QUERY, 0));
		send_request(make_request(OP_QUERY, 1));
		send_request(make_request(OP_HOP, 0));
		send_request(make_request(OP_DELETE, 0));
		send_request(make_request(OP_DELETE, 1));
		send_request(make_request(3'd5, 1));
		send_request(make_request(3'd7, 1));
		clock_ms = clock_ms + 2000;
		send_request(make_request(OP_QUERY, 32'hFFFF_FFFF));
		// fill the table, then one more add hits the full case
		for (int i = 1; i <= DEPTH; i++) begin
			quiet_stretch = 1;
			send_request(make_request(OP_ADD, 32'h100 + i));
		end
		send_request(make_request(OP_ADD, 32'h7777));
		send_request(make_request(OP_HOP, 0));
		send_request(make_request(OP_CLEAR, 0));
		quiet_stretch = 0;

		set_lifetime(20'd1);
		random_phase(200, 4);
		set_lifetime(20'hFFFFF);
		random_phase(400, 8);
		set_lifetime(20'd0);
		random_phase(100, 4);
		set_lifetime(20'd300 + 20'($urandom_range(3000)));
		quiet_stretch = 1;
		random_phase(250, 8);
		quiet_stretch = 0;
		drain();
		random_phase(300, 6);
		set_lifetime(20'd999999);
		random_phase(250, 8);

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

>>> filelist.f
src/gnt_pkg.sv
src/gnt_ram.sv
src/gnt_ctrl.sv
src/gnt_dp.sv
src/greedy_neighbour_table_core.sv
test/testbench.sv
